@@ sv/tkhm_pkg.sv @@
package tkhm_pkg;

  localparam int TableSizeDef  = 1024;
  localparam int WaysDef       = 4;
  localparam int KeyWidthDef   = 32;
  localparam int ValueWidthDef = 32;

  localparam int FieldW = 32;
  localparam int CountW = 13;
  localparam int ModeW  = 3;

  localparam logic [63:0] HashSeed  = 64'd731;
  localparam int          HashShift = 5;

  localparam logic [ModeW-1:0] MODE_CONTAINS = 3'd0;
  localparam logic [ModeW-1:0] MODE_GET      = 3'd1;
  localparam logic [ModeW-1:0] MODE_PUT      = 3'd2;
  localparam logic [ModeW-1:0] MODE_POP      = 3'd3;
  localparam logic [ModeW-1:0] MODE_REMOVE   = 3'd4;

  typedef struct packed {
    logic              hit;
    logic [FieldW-1:0] old_value;
    logic              bucket_full;
    logic [CountW-1:0] removed_count;
    logic [CountW-1:0] entry_count;
  } result_t;

  function automatic logic [63:0] times31(input logic [63:0] v);
    times31 = (v << HashShift) - v;
  endfunction

endpackage

@@ sv/tkhm_hash.sv @@
// Pipelined bucket hash: seed plus key_x, xor key_y, xor key_z, each step followed by a multiply by 31.
module tkhm_hash #(
  parameter int KEY_WIDTH = tkhm_pkg::KeyWidthDef
) (
  input  logic                 clk,
  input  logic                 start,
  input  logic [KEY_WIDTH-1:0] key_x,
  input  logic [KEY_WIDTH-1:0] key_y,
  input  logic [KEY_WIDTH-1:0] key_z,
  output logic [63:0]          hash
);
  import tkhm_pkg::*;

  logic [63:0] h1_r, h2_r;
  logic [KEY_WIDTH-1:0] y_r, z_r, z2_r;

  always_ff @(posedge clk) begin
    if (start) begin
      h1_r <= times31(HashSeed + 64'(key_x));
      y_r  <= key_y;
      z_r  <= key_z;
    end
    h2_r <= times31(h1_r ^ 64'(y_r));
    z2_r <= z_r;
  end

  assign hash = times31(h2_r ^ 64'(z2_r));

endmodule

@@ sv/three_key_hash_map_core.sv @@
// Three-key hash map core.
// Input channel in_*: one request per transaction (mode in tuser, keys and value in tdata).
// Output channel out_*: one result per request, held in an output register until taken.
// Put/get/contains/pop pass from acceptance to out_tvalid through hash states H1 and H2,
// RD (bucket register), WAY (each way read and compared in turn), UPD (update), DONE
// (posts the result), then the output register.
// Remove-all sweeps every slot, one per cycle, in SCAN, then finishes in DRAIN and DONE.
// Throughput: one request at a time; a new request is accepted once the previous result
// has been moved to the output register, so the next request overlaps the wait for the
// receiver.
// The bucket is the low bits of the hash; TABLE_SIZE must be a power of two.
// Slot storage is one synchronous memory holding all fields of an entry, plus a valid-bit
// memory; read data appears in the cycle after its address is presented.
// Reset: a clearing pass walks the valid memory one slot per cycle, over all
// TABLE_SIZE*WAYS slots, with in_tready low; the entry count resets to zero.
// A stall on out_tready holds the result and keeps in_tready low once
// a second result is ready.
module three_key_hash_map_core #(
  parameter int TABLE_SIZE  = tkhm_pkg::TableSizeDef,
  parameter int WAYS        = tkhm_pkg::WaysDef,
  parameter int KEY_WIDTH   = tkhm_pkg::KeyWidthDef,
  parameter int VALUE_WIDTH = tkhm_pkg::ValueWidthDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // key_x, key_y, key_z, new_value
  input  logic [tkhm_pkg::ModeW-1:0] in_tuser, // mode
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,  // hit, old_value, bucket_full, removed_count,
                                    // entry_count, zero fill
  output logic          out_tuser   // unused, zero
);
  import tkhm_pkg::*;

  localparam int Slots  = TABLE_SIZE * WAYS;
  localparam int SlotW  = $clog2(Slots);
  localparam int BktW   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int WayW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WayCW  = $clog2(WAYS + 1);
  localparam int CntW   = $clog2(Slots + 1);
  localparam int EntW   = KEY_WIDTH * 3 + VALUE_WIDTH;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_H1    = 4'd2;
  localparam logic [3:0] ST_H2    = 4'd3;
  localparam logic [3:0] ST_RD    = 4'd4;
  localparam logic [3:0] ST_WAY   = 4'd5;
  localparam logic [3:0] ST_UPD   = 4'd6;
  localparam logic [3:0] ST_SCAN  = 4'd7;
  localparam logic [3:0] ST_DRAIN = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0] state_r, state_nxt;

  // request registers
  logic [ModeW-1:0]       mode_r;
  logic [KEY_WIDTH-1:0]   kx_r, ky_r, kz_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [63:0]            hash;
  logic [BktW-1:0]        bkt_r;

  // memories: one entry array plus a valid array
  logic [EntW-1:0] ent_mem [Slots];
  logic            vld_mem [Slots];
  logic [EntW-1:0] ent_q;
  logic            vld_q;

  logic             rd_en, wr_ent, wr_vld, vld_wdata;
  logic [SlotW-1:0] rd_addr, wr_addr;
  logic [EntW-1:0]  ent_wdata;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ent_q <= ent_mem[rd_addr];
      vld_q <= vld_mem[rd_addr];
    end
    if (wr_ent) ent_mem[wr_addr] <= ent_wdata;
    if (wr_vld) vld_mem[wr_addr] <= vld_wdata;
  end

  // sweep / way counter
  logic [CntW-1:0]  idx_r, idx_nxt;
  logic [WayCW-1:0] way_r, way_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [SlotW-1:0] rd_slot_r;

  // bucket search results
  logic             found_r, found_nxt, free_r, free_nxt;
  logic [WayW-1:0]  fway_r, fway_nxt, eway_r, eway_nxt;
  logic [VALUE_WIDTH-1:0] fval_r, fval_nxt;

  logic [CntW-1:0]  entries_r, entries_nxt, removed_r, removed_nxt;

  result_t res_r, res_nxt;
  logic    res_v_r, res_v_nxt;
  logic    out_v_r;
  result_t out_r;

  logic [KEY_WIDTH-1:0]   q_x, q_y, q_z;
  logic [VALUE_WIDTH-1:0] q_v;
  assign {q_x, q_y, q_z, q_v} = ent_q;

  tkhm_hash #(.KEY_WIDTH(KEY_WIDTH)) u_hash (
    .clk   (clk),
    .start (state_r == ST_IDLE),
    .key_x (KEY_WIDTH'(in_tdata[0 +: FieldW])),
    .key_y (KEY_WIDTH'(in_tdata[FieldW +: FieldW])),
    .key_z (KEY_WIDTH'(in_tdata[2*FieldW +: FieldW])),
    .hash  (hash)
  );

  assign in_tready = (state_r == ST_IDLE) && !res_v_r;
  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  function automatic logic [SlotW-1:0] slot_of(input logic [BktW-1:0] b,
                                              input logic [WayW-1:0] w);
    slot_of = SlotW'(b) * SlotW'(WAYS) + SlotW'(w);
  endfunction

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    way_nxt     = way_r;
    rd_pend_nxt = 1'b0;
    found_nxt   = found_r;
    free_nxt    = free_r;
    fway_nxt    = fway_r;
    eway_nxt    = eway_r;
    fval_nxt    = fval_r;
    entries_nxt = entries_r;
    removed_nxt = removed_r;
    res_nxt     = res_r;
    res_v_nxt   = res_v_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_ent      = 1'b0;
    wr_vld      = 1'b0;
    vld_wdata   = 1'b0;
    wr_addr     = '0;
    ent_wdata   = {kx_r, ky_r, kz_r, val_r};

    if (res_v_r && !(out_v_r && !out_tready)) res_v_nxt = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        wr_vld  = 1'b1;
        wr_addr = idx_r[SlotW-1:0];
        idx_nxt = idx_r + 1'b1;
        if (idx_r == CntW'(Slots - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) state_nxt = (in_tuser == MODE_REMOVE) ? ST_SCAN : ST_H1;
        idx_nxt     = '0;
        removed_nxt = '0;
      end
      ST_H1: state_nxt = ST_H2;
      ST_H2: state_nxt = ST_RD;
      ST_RD: begin
        way_nxt   = '0;
        found_nxt = 1'b0;
        free_nxt  = 1'b0;
        state_nxt = ST_WAY;
      end
      ST_WAY: begin
        // issue reads for way way_r, evaluate the previous read
        if (rd_pend_r) begin
          if (vld_q && q_x == kx_r && q_y == ky_r && q_z == kz_r && !found_r) begin
            found_nxt = 1'b1;
            fway_nxt  = WayW'(way_r - 1'b1);
            fval_nxt  = q_v;
          end
          if (!vld_q && !free_r) begin
            free_nxt = 1'b1;
            eway_nxt = WayW'(way_r - 1'b1);
          end
        end
        if (way_r == WayCW'(WAYS)) begin
          state_nxt = ST_UPD;
        end else begin
          rd_en       = 1'b1;
          rd_addr     = slot_of(bkt_r, WayW'(way_r));
          rd_pend_nxt = 1'b1;
          way_nxt     = way_r + 1'b1;
        end
      end
      ST_UPD: begin
        res_nxt = '0;
        case (mode_r)
          MODE_CONTAINS: res_nxt.hit = found_r;
          MODE_GET: begin
            res_nxt.hit       = found_r;
            res_nxt.old_value = found_r ? FieldW'(fval_r) : '0;
          end
          MODE_PUT: begin
            if (found_r) begin
              res_nxt.hit       = 1'b1;
              res_nxt.old_value = FieldW'(fval_r);
              wr_ent  = 1'b1;
              wr_addr = slot_of(bkt_r, fway_r);
            end else if (free_r) begin
              wr_ent      = 1'b1;
              wr_vld      = 1'b1;
              vld_wdata   = 1'b1;
              wr_addr     = slot_of(bkt_r, eway_r);
              entries_nxt = entries_r + 1'b1;
            end else begin
              res_nxt.bucket_full = 1'b1;
            end
          end
          MODE_POP: begin
            if (found_r) begin
              res_nxt.hit       = 1'b1;
              res_nxt.old_value = FieldW'(fval_r);
              wr_vld      = 1'b1;
              wr_addr     = slot_of(bkt_r, fway_r);
              entries_nxt = entries_r - 1'b1;
            end
          end
          default: ;
        endcase
        res_nxt.entry_count = CountW'(entries_nxt);
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        // read slot idx_r; evaluate slot read last cycle
        if (rd_pend_r && vld_q && q_v == val_r) begin
          wr_vld      = 1'b1;
          wr_addr     = rd_slot_r;
          removed_nxt = removed_r + 1'b1;
        end
        rd_en       = 1'b1;
        rd_addr     = idx_r[SlotW-1:0];
        rd_pend_nxt = 1'b1;
        idx_nxt     = idx_r + 1'b1;
        if (idx_r == CntW'(Slots - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (vld_q && q_v == val_r) begin
          wr_vld      = 1'b1;
          wr_addr     = rd_slot_r;
          removed_nxt = removed_r + 1'b1;
        end
        res_nxt               = '0;
        res_nxt.removed_count = CountW'(removed_nxt);
        entries_nxt           = entries_r - removed_nxt;
        res_nxt.entry_count   = CountW'(entries_nxt);
        state_nxt             = ST_DONE;
      end
      ST_DONE: begin
        // wait for a free result slot
        if (!res_v_nxt) begin
          res_v_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      idx_r     <= '0;
      entries_r <= '0;
      res_v_r   <= 1'b0;
      out_v_r   <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      entries_r <= entries_nxt;
      res_v_r   <= res_v_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (res_v_r && !(out_v_r && !out_tready)) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    way_r     <= way_nxt;
    found_r   <= found_nxt;
    free_r    <= free_nxt;
    fway_r    <= fway_nxt;
    eway_r    <= eway_nxt;
    fval_r    <= fval_nxt;
    removed_r <= removed_nxt;
    res_r     <= res_nxt;
    rd_slot_r <= rd_addr;
    if (res_v_r && !(out_v_r && !out_tready)) out_r <= res_r;
    if (in_acc) begin
      mode_r <= in_tuser;
      kx_r   <= KEY_WIDTH'(in_tdata[0 +: FieldW]);
      ky_r   <= KEY_WIDTH'(in_tdata[FieldW +: FieldW]);
      kz_r   <= KEY_WIDTH'(in_tdata[2*FieldW +: FieldW]);
      val_r  <= VALUE_WIDTH'(in_tdata[3*FieldW +: FieldW]);
    end
    if (state_r == ST_H2) bkt_r <= hash[BktW-1:0];
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0, out_r.entry_count, out_r.removed_count, out_r.bucket_full,
                       out_r.old_value, out_r.hit};
  assign out_tuser  = 1'b0;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    entries_r <= CntW'(Slots)) else $error("entry count overflow");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> res_v_r) else $error("result lost");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == ST_IDLE)) else $error("accept while busy");
  a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && mode_r == MODE_PUT && !found_r && !free_r) |=>
    (entries_r == $past(entries_r))) else $error("full bucket changed count");
`endif

endmodule
